/* design/sjisv_pkg.sv */
// Shared types and byte constants for the SJIS string validator.
// No dependencies; used by sjisv_step and the top level.
package sjisv_pkg;

  // one byte of the candidate string
  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_item_t;

  // verdict for one buffer
  typedef struct packed {
    logic valid_text;
    logic all_latin;
  } out_item_t;

  localparam int unsigned CHAR_COUNT_W = 9;

  // per-string scan state
  typedef struct packed {
    logic                    expect_trail;
    logic                    latin_so_far;
    logic                    saw_double_byte;
    logic                    failed;
    logic                    terminated;
    logic [CHAR_COUNT_W-1:0] char_count;
  } str_state_t;

  localparam logic [CHAR_COUNT_W-1:0] CHAR_COUNT_MAX = '1;

  localparam str_state_t STR_STATE_RESET = '{
    expect_trail:    1'b0,
    latin_so_far:    1'b1,
    saw_double_byte: 1'b0,
    failed:          1'b0,
    terminated:      1'b0,
    char_count:      '0
  };

  localparam logic [7:0] KANA_LIMIT_RESET = 8'd3;

  // byte boundaries
  localparam logic [7:0] BYTE_NUL      = 8'h00;
  localparam logic [7:0] BYTE_LF       = 8'h0A;
  localparam logic [7:0] BYTE_SPACE    = 8'h20;
  localparam logic [7:0] BYTE_DEL      = 8'h7F;
  localparam logic [7:0] BYTE_HI_START = 8'h80;
  localparam logic [7:0] LEAD1_LAST    = 8'h9F;
  localparam logic [7:0] BYTE_KANA_GAP = 8'hA0;
  localparam logic [7:0] LEAD2_START   = 8'hE0;
  localparam logic [7:0] BYTE_F0       = 8'hF0;
  localparam logic [7:0] TRAIL_MIN     = 8'h40;
  localparam logic [7:0] TRAIL_END     = 8'hFD;

endpackage

/* design/sjisv_step.sv */
// Per-byte scan logic: next string state and end-of-buffer verdict.
// Depends on sjisv_pkg.
module sjisv_step (
  input  sjisv_pkg::str_state_t state_cur,
  input  sjisv_pkg::in_item_t   item,
  input  logic [7:0]            kana_limit,
  output sjisv_pkg::str_state_t state_next,
  output sjisv_pkg::out_item_t  verdict
);
  import sjisv_pkg::*;

  logic [7:0]              b;
  str_state_t              scan;
  logic                    count_en;
  logic                    fail_fin;
  logic [CHAR_COUNT_W-1:0] limit_ext;

  assign b         = item.byte_value;
  assign limit_ext = {{(CHAR_COUNT_W-8){1'b0}}, kana_limit};

  // classify the byte against the current scan state
  always_comb begin
    scan     = state_cur;
    count_en = 1'b0;
    if (!(state_cur.failed || state_cur.terminated)) begin
      if (state_cur.expect_trail) begin
        scan.expect_trail = 1'b0;
        if (b < TRAIL_MIN || b == BYTE_DEL || b >= TRAIL_END) begin
          scan.failed = 1'b1;
        end else begin
          count_en = 1'b1;
        end
      end else if (b == BYTE_NUL) begin
        scan.terminated = 1'b1;
      end else if (b < BYTE_SPACE) begin
        if (b == BYTE_LF) begin
          count_en = 1'b1;
        end else begin
          scan.failed = 1'b1;
        end
      end else if (b < BYTE_HI_START) begin
        if (b == BYTE_DEL) begin
          scan.failed = 1'b1;
        end else begin
          count_en = 1'b1;
        end
      end else if (b <= LEAD1_LAST) begin
        if (b == BYTE_HI_START) begin
          scan.failed = 1'b1;
        end else begin
          scan.latin_so_far    = 1'b0;
          scan.saw_double_byte = 1'b1;
          scan.expect_trail    = 1'b1;
        end
      end else if (b < LEAD2_START) begin
        if (b == BYTE_KANA_GAP) begin
          scan.failed = 1'b1;
        end else begin
          scan.latin_so_far = 1'b0;
          count_en          = 1'b1;
        end
      end else if (b < BYTE_F0) begin
        scan.latin_so_far    = 1'b0;
        scan.saw_double_byte = 1'b1;
        scan.expect_trail    = 1'b1;
      end else begin
        scan.failed = 1'b1;
      end
    end
    // saturating character count
    if (count_en && scan.char_count != CHAR_COUNT_MAX) begin
      scan.char_count = scan.char_count + 1'b1;
    end
  end

  // end-of-buffer checks: dangling lead byte and short kana-only string
  always_comb begin
    fail_fin = scan.failed;
    if (!scan.failed && !scan.terminated && scan.expect_trail) begin
      fail_fin = 1'b1;
    end
    if (!fail_fin && !scan.saw_double_byte && !scan.latin_so_far &&
        scan.char_count <= limit_ext) begin
      fail_fin = 1'b1;
    end
    verdict.valid_text = ~fail_fin;
    verdict.all_latin  = scan.latin_so_far;
    state_next         = item.last_byte ? STR_STATE_RESET : scan;
  end

endmodule

/* design/shift_jis_string_validator.sv */
// Top level of the SJIS string validator: input register, scan state,
// configuration register and result register. Depends on sjisv_pkg, sjisv_step.
//
// Takes one byte per clock and can accept a new byte in every cycle, except that
// a last byte waits in the input register while the result register is full and
// stalled. A byte is scanned by sjisv_step as it leaves the input register, and
// the verdict for a buffer lands in the result register when its last byte is
// scanned. Only last bytes need room in the result register; other bytes never
// wait on the output side. The kana limit (kana_limit_r, reset 3) is written
// through cfg_*; the user must write it only while no buffer is in flight, as the block does not enforce this.
module shift_jis_string_validator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sjisv_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sjisv_pkg::out_item_t out_data,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data
);
  import sjisv_pkg::*;

  logic       in_valid_r, in_valid_nxt;
  in_item_t   in_item_r;
  str_state_t state_r, state_nxt, state_step;
  out_item_t  out_item_r, verdict;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] kana_limit_r;
  logic       in_xfer, out_xfer, out_free, fire;

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && (!in_item_r.last_byte || out_free);
  assign in_stall = in_valid_r && !fire;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  sjisv_step u_step (
    .state_cur  (state_r),
    .item       (in_item_r),
    .kana_limit (kana_limit_r),
    .state_next (state_step),
    .verdict    (verdict)
  );

  // next-value logic
  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
    state_nxt     = fire ? state_step : state_r;
    out_valid_nxt = out_valid_r;
    if (fire && in_item_r.last_byte) begin
      out_valid_nxt = 1'b1;
    end else if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      state_r      <= STR_STATE_RESET;
      kana_limit_r <= KANA_LIMIT_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
      if (cfg_wr_en) begin
        kana_limit_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_item_r <= in_data;
    end
    if (fire && in_item_r.last_byte) begin
      out_item_r <= verdict;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // a finished buffer leaves the scan state at its reset value
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_item_r.last_byte) |=> (state_r == STR_STATE_RESET))
    else $error("scan state not cleared after last byte");

  // failure latches within a buffer
  a_fail_latches: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !in_item_r.last_byte && state_r.failed) |=> state_r.failed)
    else $error("failure flag dropped within a buffer");

  // a result appears only from a last byte scan
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r ##1 out_valid_r) |-> $past(fire && in_item_r.last_byte))
    else $error("result appeared without a last byte");

  // state moves only when a byte is scanned
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(state_r))
    else $error("scan state changed without a byte");

endmodule
